// ===== hw/rtl/dtdhkq_pkg.sv =====
// Package for the double-tap / double-hold key qualifier.
// Payload structs, action and operation codes, controller/datapath links.
// No dependencies.
package dtdhkq_pkg;

  localparam int NUM_KEYS_DEF = 32;
  localparam int KEY_IDX_W    = 5;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  localparam logic [15:0] TAP_WIN_RST  = 16'd120;
  localparam logic [15:0] HOLD_WIN_RST = 16'd500;
  localparam logic [15:0] MIN_HOLD_RST = 16'd50;

  localparam logic [15:0] LETTER_LO = 16'd4;
  localparam logic [15:0] LETTER_HI = 16'd29;

  localparam logic OP_EVENT = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [2:0] ACT_DECISION = 3'd0;
  localparam logic [2:0] ACT_TAP      = 3'd1;
  localparam logic [2:0] ACT_ONESHOT  = 3'd2;
  localparam logic [2:0] ACT_LATCH    = 3'd3;
  localparam logic [2:0] ACT_RELEASE  = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_DTAP_WIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DHOLD_WIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HOLD  = 2'd2;

  typedef struct packed {
    logic                 operation;
    logic [KEY_IDX_W-1:0] key_index;
    logic                 is_managed;
    logic                 pressed;
    logic                 is_tap;
    logic [15:0]          tap_key;
    logic [3:0]           target_layer;
    logic [7:0]           mod_mask;
    logic                 caps_word_on;
    logic [15:0]          now;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] out_key;
    logic [3:0]  out_layer;
    logic [7:0]  out_mods;
    logic        pass_default;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic latch_in;
    logic scan_gen;
    logic act_do;
    logic act2_do;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic is_tick;
    logic scan_hit;
    logic act_two;
    logic can_gen;
    logic can_flush;
  } dp_status_t;

endpackage

// ===== hw/rtl/dtdhkq_dp.sv =====
// Datapath: per-key state table, config registers, result holding stage
// and output register. Depends on dtdhkq_pkg.
module dtdhkq_dp #(
  parameter int NUM_KEYS = dtdhkq_pkg::NUM_KEYS_DEF,
  parameter int KW       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dtdhkq_pkg::in_item_t              in_data,
  input  logic                              cfg_we,
  input  logic [dtdhkq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtdhkq_pkg::CFG_DATA_W-1:0] cfg_data,
  input  dtdhkq_pkg::dp_cmd_t               cmd,
  input  logic [KW-1:0]                     scan_k,
  output dtdhkq_pkg::dp_status_t            status,
  output logic                              out_valid,
  input  logic                              out_ready,
  output dtdhkq_pkg::out_item_t             out_data
);
  import dtdhkq_pkg::*;

  logic [15:0] dtw_r, dhw_r, mht_r;
  in_item_t    in_r;

  logic        pend_r  [NUM_KEYS];
  logic [15:0] pkey_r  [NUM_KEYS];
  logic [15:0] tapst_r [NUM_KEYS];
  logic [15:0] holdst_r[NUM_KEYS];
  logic [15:0] pressst_r[NUM_KEYS];
  logic        lat_r   [NUM_KEYS];

  out_item_t held_r, out_r, new_res, act_res, held_fin;
  logic      held_v_r, out_v_r;

  logic [KW-1:0] addr, idx;
  logic          managed, out_free, gen;
  logic          e_pend, e_lat, n_pend, n_lat, act_two, act_we;
  logic [15:0]   e_key, e_tap, e_hold, e_press, n_key, n_tap, n_hold, n_press;
  logic [15:0]   d_tap, d_hold, d_press;

  assign idx     = in_r.key_index[KW-1:0];
  assign managed = in_r.is_managed && (32'(in_r.key_index) < NUM_KEYS);
  assign addr    = (cmd.act_do) ? idx : scan_k;

  assign e_pend  = pend_r[addr];
  assign e_key   = pkey_r[addr];
  assign e_tap   = tapst_r[addr];
  assign e_hold  = holdst_r[addr];
  assign e_press = pressst_r[addr];
  assign e_lat   = lat_r[addr];

  assign d_tap   = in_r.now - e_tap;
  assign d_hold  = in_r.now - e_hold;
  assign d_press = in_r.now - e_press;

  assign out_free = !out_v_r || out_ready;

  always_comb begin
    status.is_tick   = (in_r.operation == OP_TICK);
    status.can_gen   = !held_v_r || out_free;
    status.can_flush = out_free;
    status.act_two   = act_two;
    if (in_r.operation == OP_TICK) begin
      status.scan_hit = e_pend && (d_tap >= dtw_r);
    end else begin
      status.scan_hit = in_r.pressed && e_pend && !(managed && scan_k == idx);
    end
  end

  // Event decision for the addressed key (entry read at idx)
  always_comb begin
    n_pend  = e_pend;
    n_key   = e_key;
    n_tap   = e_tap;
    n_hold  = e_hold;
    n_press = e_press;
    n_lat   = e_lat;
    act_two = 1'b0;
    act_res = '0;
    act_res.action       = ACT_DECISION;
    act_res.pass_default = 1'b1;
    if (managed) begin
      if (in_r.is_tap) begin
        if (in_r.pressed) begin
          if (in_r.caps_word_on && in_r.tap_key >= LETTER_LO
              && in_r.tap_key <= LETTER_HI) begin
            n_pend  = 1'b0;
            n_key   = '0;
            n_tap   = '0;
            n_hold  = '0;
            n_press = '0;
          end else if (e_pend && d_tap < dtw_r) begin
            act_res.action       = ACT_ONESHOT;
            act_res.out_layer    = in_r.target_layer;
            act_res.out_mods     = in_r.mod_mask;
            act_res.pass_default = 1'b0;
            act_two = 1'b1;
            n_pend  = 1'b0;
            n_key   = '0;
            n_tap   = '0;
          end else begin
            if (e_pend) begin
              act_res.action  = ACT_TAP;
              act_res.out_key = e_key;
              act_two = 1'b1;
            end
            act_res.pass_default = 1'b0;
            n_tap  = in_r.now;
            n_pend = 1'b1;
            n_key  = in_r.tap_key;
          end
        end else begin
          n_hold  = '0;
          n_press = '0;
        end
      end else if (in_r.pressed) begin
        n_press = in_r.now;
        n_tap   = '0;
        n_pend  = 1'b0;
        n_key   = '0;
        if (e_hold != 16'd0 && d_hold < dhw_r) begin
          n_lat = 1'b1;
          act_res.action       = ACT_LATCH;
          act_res.out_layer    = in_r.target_layer;
          act_res.out_mods     = in_r.mod_mask;
          act_res.pass_default = 1'b0;
          act_two = 1'b1;
        end else begin
          n_lat = 1'b0;
        end
      end else if (e_lat) begin
        act_res.action       = ACT_RELEASE;
        act_res.out_layer    = in_r.target_layer;
        act_res.out_mods     = in_r.mod_mask;
        act_res.pass_default = 1'b0;
        act_two = 1'b1;
        n_lat   = 1'b0;
        n_hold  = '0;
        n_press = '0;
      end else begin
        n_hold  = (d_press >= mht_r) ? e_press : 16'd0;
        n_press = '0;
      end
    end
  end

  assign act_we = cmd.act_do && managed;

  always_comb begin
    new_res = '0;
    new_res.action = ACT_DECISION;
    if (cmd.scan_gen) begin
      new_res.action  = ACT_TAP;
      new_res.out_key = e_key;
    end else if (cmd.act_do) begin
      new_res = act_res;
    end
  end

  always_comb begin
    held_fin      = held_r;
    held_fin.last = 1'b1;
  end

  assign gen = cmd.scan_gen || cmd.act_do || cmd.act2_do;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      in_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dtw_r <= TAP_WIN_RST;
      dhw_r <= HOLD_WIN_RST;
      mht_r <= MIN_HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DTAP_WIN:  dtw_r <= cfg_data;
        REG_DHOLD_WIN: dhw_r <= cfg_data;
        REG_MIN_HOLD:  mht_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        pend_r[i]    <= 1'b0;
        pkey_r[i]    <= '0;
        tapst_r[i]   <= '0;
        holdst_r[i]  <= '0;
        pressst_r[i] <= '0;
        lat_r[i]     <= 1'b0;
      end
    end else if (cmd.scan_gen) begin
      pend_r[addr] <= 1'b0;
      pkey_r[addr] <= '0;
    end else if (act_we) begin
      pend_r[addr]    <= n_pend;
      pkey_r[addr]    <= n_key;
      tapst_r[addr]   <= n_tap;
      holdst_r[addr]  <= n_hold;
      pressst_r[addr] <= n_press;
      lat_r[addr]     <= n_lat;
    end
  end

  // A result waits in the holding stage until the next one shows up or the item
  // is flushed, so the final one of an item can be marked last when it moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (gen) begin
        held_r   <= new_res;
        held_v_r <= 1'b1;
        if (held_v_r) begin
          out_r   <= held_r;
          out_v_r <= 1'b1;
        end else if (out_ready) begin
          out_v_r <= 1'b0;
        end
      end else if (cmd.flush && held_v_r) begin
        out_r    <= held_fin;
        out_v_r  <= 1'b1;
        held_v_r <= 1'b0;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

// ===== hw/rtl/dtdhkq_ctrl.sv =====
// Controller: sequences accept, key scan, event action and final flush.
// Depends on dtdhkq_pkg.
module dtdhkq_ctrl #(
  parameter int NUM_KEYS = dtdhkq_pkg::NUM_KEYS_DEF,
  parameter int KW       = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  dtdhkq_pkg::dp_status_t status,
  output dtdhkq_pkg::dp_cmd_t    cmd,
  output logic [KW-1:0]          scan_k
);
  import dtdhkq_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_ACT   = 3'd2;
  localparam logic [2:0] S_ACT2  = 3'd3;
  localparam logic [2:0] S_FLUSH = 3'd4;
  localparam logic [KW-1:0] K_LAST = KW'(NUM_KEYS - 1);

  logic [2:0]    state_r, state_nxt;
  logic [KW-1:0] k_r, k_nxt;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          k_nxt        = '0;
          state_nxt    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!status.scan_hit || status.can_gen) begin
          cmd.scan_gen = status.scan_hit;
          k_nxt        = k_r + 1'b1;
          if (k_r == K_LAST) begin
            state_nxt = status.is_tick ? S_FLUSH : S_ACT;
          end
        end
      end
      S_ACT: begin
        if (status.can_gen) begin
          cmd.act_do = 1'b1;
          state_nxt  = status.act_two ? S_ACT2 : S_FLUSH;
        end
      end
      S_ACT2: begin
        if (status.can_gen) begin
          cmd.act2_do = 1'b1;
          state_nxt   = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (status.can_flush) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
    end
  end

  assign scan_k = k_r;

endmodule

// ===== hw/rtl/double_tap_double_hold_key_qualifier_unit.sv =====
// Double-tap / double-hold key qualifier, top level.
// Instantiates dtdhkq_ctrl and dtdhkq_dp; depends on dtdhkq_pkg.
//
// One item at a time: an accepted item walks the key table one entry per
// cycle while the output keeps up, to flush or time out pending taps;
// a key event then goes through S_ACT, and S_ACT2 when it yields two
// results, and every item ends in S_FLUSH, which marks its last result.
// Output stalls can hold the scan and these states. Results pass through
// a holding stage and an output register, so a result can wait on
// out_ready while the scan goes on.
// A scan tick with nothing expired yields no result.
module double_tap_double_hold_key_qualifier_unit #(
  parameter int NUM_KEYS = dtdhkq_pkg::NUM_KEYS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  dtdhkq_pkg::in_item_t              in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output dtdhkq_pkg::out_item_t             out_data,
  input  logic                              cfg_we,
  input  logic [dtdhkq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dtdhkq_pkg::CFG_DATA_W-1:0] cfg_data
);
  import dtdhkq_pkg::*;

  localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  dp_cmd_t       cmd;
  dp_status_t    status;
  logic [KW-1:0] scan_k;

  dtdhkq_ctrl #(.NUM_KEYS(NUM_KEYS), .KW(KW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .scan_k   (scan_k)
  );

  dtdhkq_dp #(.NUM_KEYS(NUM_KEYS), .KW(KW)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .scan_k    (scan_k),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== hw/rtl/dtdhkq_checker.sv =====
// Port-level checks for the key qualifier, bound to the top level.
// Depends on dtdhkq_pkg.
module dtdhkq_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input dtdhkq_pkg::out_item_t out_data,
  input logic                  out_valid,
  input logic                  out_ready
);
  import dtdhkq_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one item in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // a decision always closes its item
  a_dec_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action == ACT_DECISION |-> out_data.last)
    else $error("decision not marked last");

  // only decisions carry pass_default
  a_pass_dec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.action != ACT_DECISION |-> !out_data.pass_default)
    else $error("pass_default on a non-decision");

endmodule

bind double_tap_double_hold_key_qualifier_unit dtdhkq_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_data  (out_data),
  .out_valid (out_valid),
  .out_ready (out_ready)
);

// ===== verif/tb_top.sv =====
// Testbench for the double-tap / double-hold key qualifier.
// Driver and monitor blocks around a behavioral predictor; needs dtdhkq_pkg and the unit.
`timescale 1ns / 100ps

module tb_top;
  import dtdhkq_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  double_tap_double_hold_key_qualifier_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [15:0] tap_win, hold_win, min_hold;
  logic        pend_flag [32];
  logic [15:0] pend_key [32];
  logic [15:0] tap_stamp [32];
  logic [15:0] hold_stamp [32];
  logic [15:0] press_at [32];
  logic        latched [32];

  in_item_t  key_events [$];
  out_item_t expected_results [$];
  int  errors = 0;
  bit  quiet_mode = 0;    // no idling in the last part
  bit  hold_off_req = 0;  // asks the receiver for a long stall
  bit  send_pause = 0;

  function automatic out_item_t mk(logic [2:0] a, logic [15:0] k, logic [3:0] l,
                                   logic [7:0] m, logic p);
    out_item_t r;
    r.action = a; r.out_key = k; r.out_layer = l; r.out_mods = m;
    r.pass_default = p; r.last = 1'b0;
    return r;
  endfunction

  task automatic push_tap(int k);
    expected_results.push_back(mk(ACT_TAP, pend_key[k], 4'd0, 8'd0, 1'b0));
    pend_flag[k] = 1'b0;
    pend_key[k] = '0;
  endtask

  task automatic qualify_event(in_item_t it);
    int n0;
    int i;
    logic mg;
    n0 = expected_results.size();
    i = int'(it.key_index);
    mg = it.is_managed;
    if (it.operation == OP_TICK) begin
      for (int k = 0; k < 32; k++)
        if (pend_flag[k] && 16'(it.now - tap_stamp[k]) >= tap_win) push_tap(k);
      if (expected_results.size() > n0)
        expected_results[expected_results.size()-1].last = 1'b1;
      return;
    end
    if (it.pressed)
      for (int k = 0; k < 32; k++)
        if (pend_flag[k] && !(mg && k == i)) push_tap(k);
    if (!mg) begin
      expected_results.push_back(mk(ACT_DECISION, '0, '0, '0, 1'b1));
    end else if (it.is_tap) begin
      if (it.pressed) begin
        if (it.tap_key >= LETTER_LO && it.tap_key <= LETTER_HI && it.caps_word_on) begin
          pend_flag[i] = 1'b0; pend_key[i] = '0; tap_stamp[i] = '0;
          hold_stamp[i] = '0; press_at[i] = '0;
          expected_results.push_back(mk(ACT_DECISION, '0, '0, '0, 1'b1));
        end else if (pend_flag[i] && 16'(it.now - tap_stamp[i]) < tap_win) begin
          expected_results.push_back(mk(ACT_ONESHOT, '0, it.target_layer, it.mod_mask,
                                        1'b0));
          pend_flag[i] = 1'b0; pend_key[i] = '0; tap_stamp[i] = '0;
          expected_results.push_back(mk(ACT_DECISION, '0, '0, '0, 1'b0));
        end else begin
          if (pend_flag[i]) push_tap(i);
          tap_stamp[i] = it.now; pend_flag[i] = 1'b1; pend_key[i] = it.tap_key;
          expected_results.push_back(mk(ACT_DECISION, '0, '0, '0, 1'b0));
        end
      end else begin
        hold_stamp[i] = '0; press_at[i] = '0;
        expected_results.push_back(mk(ACT_DECISION, '0, '0, '0, 1'b1));
      end
    end else if (it.pressed) begin
      press_at[i] = it.now; tap_stamp[i] = '0; pend_flag[i] = 1'b0; pend_key[i] = '0;
      if (hold_stamp[i] != 16'd0 && 16'(it.now - hold_stamp[i]) < hold_win) begin
        latched[i] = 1'b1;
        expected_results.push_back(mk(ACT_LATCH, '0, it.target_layer, it.mod_mask, 1'b0));
        expected_results.push_back(mk(ACT_DECISION, '0, '0, '0, 1'b0));
      end else begin
        latched[i] = 1'b0;
        expected_results.push_back(mk(ACT_DECISION, '0, '0, '0, 1'b1));
      end
    end else if (latched[i]) begin
      expected_results.push_back(mk(ACT_RELEASE, '0, it.target_layer, it.mod_mask, 1'b0));
      latched[i] = 1'b0; hold_stamp[i] = '0; press_at[i] = '0;
      expected_results.push_back(mk(ACT_DECISION, '0, '0, '0, 1'b0));
    end else begin
      hold_stamp[i] = (16'(it.now - press_at[i]) >= min_hold) ? press_at[i] : 16'd0;
      press_at[i] = '0;
      expected_results.push_back(mk(ACT_DECISION, '0, '0, '0, 1'b1));
    end
    expected_results[expected_results.size()-1].last = 1'b1;
  endtask

  // driver
  int in_gap = 0;
  always @(posedge clk) begin
    if (in_valid && in_ready) qualify_event(in_data);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid <= 1'b0;
      end else if (!send_pause && key_events.size() > 0
                   && !(!quiet_mode && $urandom_range(0, 5) == 0)) begin
        in_data <= key_events.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
        if (!quiet_mode && key_events.size() > 0) in_gap <= $urandom_range(0, 7);
      end
    end
  end

  // monitor and receiver; a long stall is counted here once requested
  int out_gap = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result action=%0d", out_data.action);
        errors++;
      end else begin
        out_item_t e;
        e = expected_results.pop_front();
        if (out_data.action !== e.action) begin
          $error("action exp %0d got %0d", e.action, out_data.action); errors++;
        end
        if (out_data.out_key !== e.out_key) begin
          $error("out_key exp %0h got %0h", e.out_key, out_data.out_key); errors++;
        end
        if (out_data.out_layer !== e.out_layer) begin
          $error("out_layer exp %0d got %0d", e.out_layer, out_data.out_layer); errors++;
        end
        if (out_data.out_mods !== e.out_mods) begin
          $error("out_mods exp %0h got %0h", e.out_mods, out_data.out_mods); errors++;
        end
        if (out_data.pass_default !== e.pass_default) begin
          $error("pass_default exp %0b got %0b", e.pass_default, out_data.pass_default);
          errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last exp %0b got %0b", e.last, out_data.last); errors++;
        end
      end
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_off_req) begin
      hold_left <= 3000;
      out_ready <= 1'b0;
    end else if (quiet_mode) begin
      out_ready <= 1'b1;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      out_gap <= $urandom_range(0, 7);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: cycles with no transfer on either channel
  int stuck = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck > 20000) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic in_item_t ev(logic [4:0] idx, logic pr, logic tp, logic [15:0] key,
                                  logic [15:0] t);
    in_item_t it;
    it.operation = OP_EVENT; it.key_index = idx; it.is_managed = 1'b1;
    it.pressed = pr; it.is_tap = tp; it.tap_key = key;
    it.target_layer = 4'($urandom); it.mod_mask = 8'($urandom);
    it.caps_word_on = 1'b0; it.now = t;
    return it;
  endfunction

  function automatic in_item_t tick(logic [15:0] t);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.operation = OP_TICK; it.now = t;
    return it;
  endfunction

  task automatic drain();
    while (key_events.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] r, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= r; cfg_data <= v;
    case (r)
      REG_DTAP_WIN:  tap_win = v;
      REG_DHOLD_WIN: hold_win = v;
      default:       min_hold = v;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // one random phase; sequences are mostly well-formed press/release pairs
  task automatic random_phase(int count);
    logic [15:0] t;
    in_item_t it;
    int k;
    t = 16'($urandom);
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(0, 5);
      t += 16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 300));
      case ($urandom_range(0, 9))
        0, 1, 2: begin  // tap press + release, maybe double
          it = ev(5'(k), 1'b1, 1'b1, 16'($urandom_range(0, 40)), t);
          it.caps_word_on = $urandom_range(0, 3) == 0;
          key_events.push_back(it);
          key_events.push_back(ev(5'(k), 1'b0, 1'b1, it.tap_key, t + 16'd5));
        end
        3, 4, 5: begin  // hold press + release
          key_events.push_back(ev(5'(k), 1'b1, 1'b0, 16'($urandom), t));
          t += 16'($urandom_range(0, 200));
          key_events.push_back(ev(5'(k), 1'b0, 1'b0, 16'($urandom), t));
        end
        6, 7: key_events.push_back(tick(t));
        default: begin  // noise
          it = in_item_t'({$urandom, $urandom});
          it.operation = OP_EVENT;
          key_events.push_back(it);
        end
      endcase
    end
  endtask

  initial begin
    tap_win = TAP_WIN_RST; hold_win = HOLD_WIN_RST;
    min_hold = MIN_HOLD_RST;
    for (int k = 0; k < 32; k++) begin
      pend_flag[k] = 1'b0; pend_key[k] = '0; tap_stamp[k] = '0;
      hold_stamp[k] = '0; press_at[k] = '0; latched[k] = 1'b0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: double tap, tap timeout, flush, caps word, double hold, unmanaged
    key_events.push_back(ev(5'd0, 1'b1, 1'b1, 16'hFFFF, 16'd100));
    key_events.push_back(ev(5'd0, 1'b0, 1'b1, 16'hFFFF, 16'd110));
    key_events.push_back(ev(5'd0, 1'b1, 1'b1, 16'hFFFF, 16'd150));
    key_events.push_back(ev(5'd31, 1'b1, 1'b1, 16'd0, 16'd200));
    key_events.push_back(ev(5'd1, 1'b1, 1'b1, 16'd5, 16'd210));
    key_events.push_back(tick(16'd250));
    key_events.push_back(tick(16'd400));
    key_events.push_back(ev(5'd2, 1'b1, 1'b1, 16'd7, 16'd410));
    key_events.push_back(ev(5'd3, 1'b1, 1'b0, 16'd0, 16'd420));
    begin
      in_item_t c;
      c = ev(5'd2, 1'b1, 1'b1, 16'd4, 16'd430); c.caps_word_on = 1'b1;
      key_events.push_back(c);
      c = ev(5'd2, 1'b1, 1'b1, 16'd29, 16'd431); c.caps_word_on = 1'b1;
      key_events.push_back(c);
      c = ev(5'd2, 1'b1, 1'b1, 16'd30, 16'd432); c.caps_word_on = 1'b1;
      key_events.push_back(c);
      c = ev(5'd4, 1'b1, 1'b0, 16'd0, 16'd500); key_events.push_back(c);
      c = ev(5'd4, 1'b0, 1'b0, 16'd0, 16'd600); key_events.push_back(c);
      c = ev(5'd4, 1'b1, 1'b0, 16'd0, 16'd700); c.mod_mask = 8'hFF; c.target_layer = 4'hF;
      key_events.push_back(c);
      c = ev(5'd4, 1'b0, 1'b0, 16'd0, 16'd710); key_events.push_back(c);
      c = ev(5'd5, 1'b1, 1'b0, 16'd0, 16'hFFF0); key_events.push_back(c);
      c = ev(5'd5, 1'b0, 1'b0, 16'd0, 16'd20); key_events.push_back(c);
      c = ev(5'd6, 1'b1, 1'b1, 16'd9, 16'd30); c.is_managed = 1'b0; key_events.push_back(c);
      c = ev(5'd6, 1'b0, 1'b1, 16'd9, 16'd30); c.is_managed = 1'b0; key_events.push_back(c);
      key_events.push_back(tick(16'hFFFF));
    end
    drain();

    // long receiver stall while items keep coming
    hold_off_req = 1;
    random_phase(20);
    repeat (2) @(posedge clk);
    hold_off_req = 0;
    drain();

    write_reg(REG_DTAP_WIN, 16'd0); write_reg(REG_DHOLD_WIN, 16'hFFFF);
    write_reg(REG_MIN_HOLD, 16'd0);
    random_phase(30);
    drain();
    write_reg(REG_DTAP_WIN, 16'hFFFF); write_reg(REG_DHOLD_WIN, 16'd0);
    write_reg(REG_MIN_HOLD, 16'hFFFF);
    random_phase(25);
    // sender waits for every expected result
    while (key_events.size() > 0 || in_valid) @(posedge clk);
    send_pause = 1;
    drain();
    send_pause = 0;
    write_reg(REG_DTAP_WIN, 16'd150); write_reg(REG_DHOLD_WIN, 16'd400);
    write_reg(REG_MIN_HOLD, 16'd40);
    random_phase(40);
    drain();
    quiet_mode = 1;
    random_phase(20);
    drain();

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/dtdhkq_pkg.sv
hw/rtl/dtdhkq_dp.sv
hw/rtl/dtdhkq_ctrl.sv
hw/rtl/double_tap_double_hold_key_qualifier_unit.sv
hw/rtl/dtdhkq_checker.sv
verif/tb_top.sv
